>>> rtl/grmc_pkg.sv
// Shared constants, types and table functions for the column ray caster.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package grmc_pkg;

  localparam int MAP_SIDE   = 64;
  localparam int CELL_COUNT = MAP_SIDE * MAP_SIDE;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int MAX_STEPS  = 4096;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int FRAC_BITS  = 22;
  localparam int TRC_W      = 34;
  localparam int XI_W       = TRC_W - FRAC_BITS;
  localparam int DVD_W      = 39;
  localparam int DVS_W      = 22;
  localparam int DCNT_W     = $clog2(DVD_W);
  localparam int SQ_W       = 44;

  localparam logic [FRAC_BITS-1:0] TEX_LOW  = 22'd419430;
  localparam logic [FRAC_BITS-1:0] TEX_HIGH = 22'd3774874;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_FIELD_OF_VIEW  = 3'd2;
  localparam logic [2:0] CFG_STEP_LENGTH    = 3'd3;
  localparam logic [2:0] CFG_VIEW_LIMIT     = 3'd4;
  localparam logic [2:0] CFG_SHADE_DISTANCE = 3'd5;
  localparam logic [2:0] CFG_WALL_SCALE     = 3'd6;

  typedef enum logic [1:0] {
    DIV_ANGLE = 2'd0,
    DIV_HALF  = 2'd1,
    DIV_SHADE = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic               cap;
    logic               clr_we;
    logic [CELL_AW-1:0] clr_addr;
    logic               wr;
    logic               div_start;
    div_sel_t           div_sel;
    logic               ang_ld;
    logic               trig_ld;
    logic               mul_ld;
    logic               rd;
    logic               adv;
    logic               sq_ld;
    logic               sum_ld;
    logic               sqrt_step;
    logic               lat_half;
    logic               fin;
    logic               out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;
    logic wall;
    logic sqrt_done;
  } dp_sts_t;

  function automatic logic [14:0] quarter_sine(input logic [4:0] k);
    logic [14:0] v;
    unique case (k)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd1606;
      5'd2:  v = 15'd3196;
      5'd3:  v = 15'd4756;
      5'd4:  v = 15'd6270;
      5'd5:  v = 15'd7723;
      5'd6:  v = 15'd9102;
      5'd7:  v = 15'd10394;
      5'd8:  v = 15'd11585;
      5'd9:  v = 15'd12665;
      5'd10: v = 15'd13623;
      5'd11: v = 15'd14449;
      5'd12: v = 15'd15137;
      5'd13: v = 15'd15678;
      5'd14: v = 15'd16069;
      5'd15: v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Q3.14 sine, quarter table with linear interpolation over 10 bits
  function automatic logic signed [16:0] sine_q14(input logic [15:0] a);
    logic [14:0] r;
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [10:0] dif;
    logic [20:0] prod;
    logic [14:0] v;
    r = {1'b0, a[13:0]};
    if (a[14]) r = 15'd16384 - r;
    idx  = r[14:10];
    frac = r[9:0];
    lo   = quarter_sine(idx);
    hi   = quarter_sine(idx + 5'd1);
    dif  = 11'(hi - lo);
    prod = dif * frac;
    if (idx >= 5'd16) v = 15'd16384;
    else v = lo + 15'(prod[20:10]);
    return a[15] ? -$signed({2'b00, v}) : $signed({2'b00, v});
  endfunction

  function automatic logic signed [1:0] wall_pattern(input logic [3:0] k);
    logic signed [1:0] p;
    unique case (k)
      4'd0, 4'd15: p = -2'sd1;
      4'd3, 4'd4, 4'd6, 4'd10, 4'd11, 4'd12: p = 2'sd1;
      default: p = 2'sd0;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/grmc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the caster.
// Depends on grmc_pkg.
`timescale 1ns / 1ps
module grmc_div import grmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  q_r;
  logic [DVS_W:0]    rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r[DVS_W-1:0], q_r[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/grmc_datapath.sv
// Caster datapath: config registers, wall map, tracer, square root,
// result registers. Depends on grmc_pkg and grmc_div.
`timescale 1ns / 1ps
module grmc_datapath import grmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [11:0] in_cell_index,
  input  logic        in_cell_is_wall,
  input  logic [9:0]  in_column,
  input  logic [15:0] in_camera_x,
  input  logic [15:0] in_camera_y,
  input  logic [15:0] in_camera_angle,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [9:0]  out_column_out,
  output logic [15:0] out_distance,
  output logic [15:0] out_half_height,
  output logic [2:0]  out_shade
);

  // configuration
  logic [10:0] width_r, height_r;
  logic [15:0] fov_r, step_r, limit_r, wscale_r;
  logic [7:0]  sdist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd80;
      height_r <= 11'd24;
      fov_r    <= 16'd10923;
      step_r   <= 16'd26;
      limit_r  <= 16'd16384;
      sdist_r  <= 8'd16;
      wscale_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:   width_r  <= cfg_wdata[10:0];
        CFG_SCREEN_HEIGHT:  height_r <= cfg_wdata[10:0];
        CFG_FIELD_OF_VIEW:  fov_r    <= cfg_wdata;
        CFG_STEP_LENGTH:    step_r   <= cfg_wdata;
        CFG_VIEW_LIMIT:     limit_r  <= cfg_wdata;
        CFG_SHADE_DISTANCE: sdist_r  <= cfg_wdata[7:0];
        CFG_WALL_SCALE:     wscale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic [11:0] cidx_r;
  logic        cwall_r;
  logic [9:0]  col_r;
  logic [15:0] camx_r, camy_r, cama_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cidx_r  <= in_cell_index;
      cwall_r <= in_cell_is_wall;
      col_r   <= in_column;
      camx_r  <= in_camera_x;
      camy_r  <= in_camera_y;
      cama_r  <= in_camera_angle;
    end
  end

  // ray offset numerator
  logic [10:0]        wid;
  logic signed [11:0] off;
  logic signed [28:0] num;
  logic [27:0]        num_mag;

  always_comb begin
    wid     = (width_r == 11'd0) ? 11'd1 : width_r;
    off     = $signed({2'b00, wid[10:1]}) - $signed({2'b00, col_r});
    num     = off * $signed({1'b0, fov_r});
    num_mag = num[28] ? 28'(-num) : 28'(num);
  end

  // shared divider
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quot;
  logic             div_done;
  logic [26:0]      hprod;
  logic [21:0]      d12;
  logic [9:0]       nint;

  assign hprod = height_r * wscale_r;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_ANGLE: begin
        dvd = DVD_W'(num_mag);
        dvs = DVS_W'(wid);
      end
      DIV_HALF: begin
        dvd = {hprod, 12'd0};
        dvs = d12;
      end
      DIV_SHADE: begin
        dvd = DVD_W'({nint, 3'b000});
        dvs = DVS_W'(sdist_r);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  grmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  // angle, trig, step vector
  logic               neg_r;
  logic [15:0]        angle_r;
  logic signed [16:0] sin_r, cos_r;
  logic signed [TRC_W-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DIV_ANGLE) neg_r <= num[28];
    if (cmd.ang_ld) angle_r <= cama_r + (neg_r ? -quot[15:0] : quot[15:0]);
    if (cmd.trig_ld) begin
      sin_r <= sine_q14(angle_r);
      cos_r <= sine_q14(angle_r + 16'd16384);
    end
    if (cmd.mul_ld) begin
      dx_r <= TRC_W'(cos_r * $signed({1'b0, step_r}));
      dy_r <= TRC_W'(sin_r * $signed({1'b0, step_r}));
    end
  end

  // tracer
  logic signed [TRC_W-1:0] tx_r, ty_r, cx, cy, lim;
  logic [STEP_W-1:0]       steps_r;
  logic [XI_W-1:0]         xi, yi;
  logic [CELL_AW-1:0]      rd_addr;
  logic                    trc_stop;

  always_comb begin
    cx  = $signed(TRC_W'({camx_r, 14'd0}));
    cy  = $signed(TRC_W'({camy_r, 14'd0}));
    lim = $signed(TRC_W'({limit_r, 14'd0}));
    xi  = tx_r[TRC_W-1:FRAC_BITS];
    yi  = ty_r[TRC_W-1:FRAC_BITS];
    rd_addr = CELL_AW'(int'(xi) * MAP_SIDE + int'(yi));
    trc_stop = (steps_r == STEP_W'(MAX_STEPS)) || (tx_r >= lim) || (ty_r >= lim) ||
               tx_r[TRC_W-1] || ty_r[TRC_W-1] ||
               (xi >= XI_W'(MAP_SIDE)) || (yi >= XI_W'(MAP_SIDE));
  end

  assign sts.stop = trc_stop;

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      tx_r <= cx;
      ty_r <= cy;
    end else if (cmd.adv) begin
      tx_r <= tx_r + dx_r;
      ty_r <= ty_r + dy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) steps_r <= '0;
    else if (cmd.mul_ld) steps_r <= '0;
    else if (cmd.adv) steps_r <= steps_r + 1'b1;
  end

  // wall map
  logic                mem [CELL_COUNT];
  logic                mem_q_r;
  logic                mem_we;
  logic [CELL_AW-1:0]  mem_wa;
  logic                mem_wd;

  always_comb begin
    mem_we = cmd.clr_we || (cmd.wr && ({1'b0, cidx_r} < 13'(CELL_COUNT)));
    mem_wa = cmd.clr_we ? cmd.clr_addr : CELL_AW'(cidx_r);
    mem_wd = cmd.clr_we ? 1'b0 : cwall_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) mem_q_r <= mem[rd_addr];
  end

  assign sts.wall = mem_q_r;

  // distance: squares, then one root bit per cycle
  logic signed [TRC_W-1:0] ddx, ddy;
  logic [TRC_W-1:0]        adx, ady;
  logic [21:0]             ax, ay;
  logic [SQ_W-1:0]         sqx_r, sqy_r, v_r, res_r, bit_r, trial;

  always_comb begin
    ddx   = tx_r - cx;
    ddy   = ty_r - cy;
    adx   = ddx[TRC_W-1] ? TRC_W'(-ddx) : TRC_W'(ddx);
    ady   = ddy[TRC_W-1] ? TRC_W'(-ddy) : TRC_W'(ddy);
    ax    = adx[31:10];
    ay    = ady[31:10];
    trial = res_r + bit_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_ld) begin
      sqx_r <= ax * ax;
      sqy_r <= ay * ay;
    end
    if (cmd.sum_ld) begin
      v_r   <= sqx_r + sqy_r;
      res_r <= '0;
      bit_r <= SQ_W'(1) << 42;
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign sts.sqrt_done = (bit_r == '0);
  assign sts.div_done  = div_done;
  assign d12  = res_r[21:0];
  assign nint = d12[21:12];

  // results
  logic [DVD_W-1:0]  half_q_r;
  logic [FRAC_BITS-1:0] fx, fy, tc;
  logic [3:0]        tex;
  logic [2:0]        band;
  logic signed [4:0] sh;
  logic [2:0]        shade_v;
  logic [15:0]       dist_v, half_v;
  logic [9:0]        res_col_r;
  logic [15:0]       res_dist_r, res_half_r;
  logic [2:0]        res_shade_r;

  always_comb begin
    fx   = tx_r[FRAC_BITS-1:0];
    fy   = ty_r[FRAC_BITS-1:0];
    tc   = (fy <= TEX_LOW || fy >= TEX_HIGH) ? fx : fy;
    tex  = tc[FRAC_BITS-1:FRAC_BITS-4];
    band = (sdist_r != 8'd0 && {2'b00, nint} < {4'd0, sdist_r}) ? quot[2:0] : 3'd7;
    sh   = $signed({2'b00, band}) - 5'(wall_pattern(tex));
    if (sh < 0) shade_v = 3'd0;
    else if (sh > 5'sd7) shade_v = 3'd7;
    else shade_v = sh[2:0];
    dist_v = (d12[21:20] != 2'b00) ? 16'hFFFF : d12[19:4];
    if (d12 == 22'd0 || half_q_r[DVD_W-1:16] != '0) half_v = 16'hFFFF;
    else half_v = half_q_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_half) half_q_r <= quot;
    if (cmd.wr) begin
      res_col_r   <= '0;
      res_dist_r  <= '0;
      res_half_r  <= '0;
      res_shade_r <= '0;
    end else if (cmd.fin) begin
      res_col_r   <= col_r;
      res_dist_r  <= dist_v;
      res_half_r  <= half_v;
      res_shade_r <= shade_v;
    end
    if (cmd.out_ld) begin
      out_column_out  <= res_col_r;
      out_distance    <= res_dist_r;
      out_half_height <= res_half_r;
      out_shade       <= res_shade_r;
    end
  end

endmodule

>>> rtl/grmc_ctrl.sv
// Caster controller: map clearing sweep, operation sequencing and the
// output handshake. Depends on grmc_pkg.
`timescale 1ns / 1ps
module grmc_ctrl import grmc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_operation,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLEAR = 16'b0000_0000_0000_0001,
    S_IDLE  = 16'b0000_0000_0000_0010,
    S_WRITE = 16'b0000_0000_0000_0100,
    S_PRE   = 16'b0000_0000_0000_1000,
    S_DIVA  = 16'b0000_0000_0001_0000,
    S_TRIG  = 16'b0000_0000_0010_0000,
    S_MUL   = 16'b0000_0000_0100_0000,
    S_CHK   = 16'b0000_0000_1000_0000,
    S_RD    = 16'b0000_0001_0000_0000,
    S_SQ    = 16'b0000_0010_0000_0000,
    S_SUM   = 16'b0000_0100_0000_0000,
    S_SQRT  = 16'b0000_1000_0000_0000,
    S_DIVH  = 16'b0001_0000_0000_0000,
    S_DIVS  = 16'b0010_0000_0000_0000,
    S_FIN   = 16'b0100_0000_0000_0000,
    S_DONE  = 16'b1000_0000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] clr_r, clr_nxt;
  logic               ov_r, ov_nxt;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cmd          = '0;
    cmd.clr_addr = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CELL_AW'(CELL_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = (in_operation == OP_CAST) ? S_PRE : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_PRE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ANGLE;
        state_nxt     = S_DIVA;
      end
      S_DIVA: begin
        if (sts.div_done) begin
          cmd.ang_ld = 1'b1;
          state_nxt  = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd.trig_ld = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (sts.stop) state_nxt = S_SQ;
        else begin
          cmd.rd    = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.wall) state_nxt = S_SQ;
        else begin
          cmd.adv   = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_SQ: begin
        cmd.sq_ld = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = S_SQRT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_HALF;
          state_nxt     = S_DIVH;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DIVH: begin
        cmd.div_sel = DIV_SHADE;
        if (sts.div_done) begin
          cmd.lat_half  = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVS;
        end
      end
      S_DIVS: begin
        if (sts.div_done) begin
          cmd.fin   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r & out_stall;
    if (cmd.out_ld) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule

>>> rtl/grid_ray_march_column_caster.sv
// Top level of the column ray caster: controller plus datapath.
// Depends on grmc_pkg, grmc_ctrl, grmc_datapath.
//
// Usage:
//  - Input channel (in_valid / in_stall): operation 0 writes one wall bit
//    of the 64x64 map, operation 1 casts the ray of one screen column.
//  - Result channel (out_valid / out_stall): one item per input item, in
//    order; a write returns all-zero fields.
//  - cfg_we / cfg_index / cfg_wdata write the seven settings; write them
//    only while no item is in flight.
//  - After reset the map is swept to empty, one cell per cycle, and in_stall
//    stays high until all 4096 cells are cleared.
//  - One item is worked on at a time. A cast marches in at most 4096 steps
//    of the tracer: each step is a bounds check and a registered map read;
//    besides the march, a cast makes three passes of the shared divider
//    and a bit-serial square root.
//  - Results sit in an output register; while out_stall is high the next
//    item is still accepted and worked on, and it waits for that register.
`timescale 1ns / 1ps
module grid_ray_march_column_caster import grmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [11:0] in_cell_index,
  input  logic        in_cell_is_wall,
  input  logic [9:0]  in_column,
  input  logic [15:0] in_camera_x,
  input  logic [15:0] in_camera_y,
  input  logic [15:0] in_camera_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_column_out,
  output logic [15:0] out_distance,
  output logic [15:0] out_half_height,
  output logic [2:0]  out_shade
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  grmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  grmc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cell_index   (in_cell_index),
    .in_cell_is_wall (in_cell_is_wall),
    .in_column       (in_column),
    .in_camera_x     (in_camera_x),
    .in_camera_y     (in_camera_y),
    .in_camera_angle (in_camera_angle),
    .cmd             (cmd),
    .sts             (sts),
    .out_column_out  (out_column_out),
    .out_distance    (out_distance),
    .out_half_height (out_half_height),
    .out_shade       (out_shade)
  );

endmodule
